FILE: rtl/midpoint_circle_rasterizer_defines.svh
// assertion macros for the circle rasterizer
// included by the rtl files that carry concurrent assertions, no other dependencies
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mcr_pkg.sv
// shared types and constants of the circle rasterizer
// no dependencies; imported by every rtl module of the block
package mcr_pkg;

	// configuration register indexes
	localparam logic [2:0] RegCenterX  = 3'd0;
	localparam logic [2:0] RegCenterY  = 3'd1;
	localparam logic [2:0] RegRadius   = 3'd2;
	localparam logic [2:0] RegPenColor = 3'd3;
	localparam logic [2:0] RegArcMode  = 3'd4;

	// palette index after reset
	localparam logic [3:0] ColorYellow = 4'd14;

	// decision variable terms
	localparam logic [15:0] DecInit = 16'd3;
	localparam logic [15:0] DecNeg  = 16'd6;
	localparam logic [15:0] DecPos  = 16'd10;

	// one column of the octant walk, handed from front to back
	typedef struct packed {
		logic [10:0] col;
		logic [10:0] row;
		logic        start;
		logic        done;
		logic        lower;
	} job_t;

endpackage

FILE: rtl/mcr_front.sv
// front end: takes input beats and steps the midpoint decision walk
// depends on mcr_pkg and the assertion macros header
`include "midpoint_circle_rasterizer_defines.svh"

module mcr_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         restart,
	input  logic [9:0]   radius,
	input  logic         lower,
	input  logic         full,
	output logic         push,
	output mcr_pkg::job_t job
);
	import mcr_pkg::*;

	logic [10:0] col_q, row_q;
	logic [15:0] dec_q;
	logic        walking_q;

	logic [10:0] c_cur, r_cur, r_dec, r_nxt, c_nxt;
	logic [15:0] p_cur, p_nxt, c4, r4;
	logic        live, done;

	always_comb begin
		c_cur = restart ? 11'd0 : col_q;
		r_cur = restart ? {1'b0, radius} : row_q;
		p_cur = restart ? (DecInit - {5'd0, radius, 1'b0}) : dec_q;
		live  = restart || walking_q;
		c4    = {{3{c_cur[10]}}, c_cur, 2'b00};
		r_dec = r_cur - 11'd1;
		r_nxt = p_cur[15] ? r_cur : r_dec;
		r4    = {{3{r_nxt[10]}}, r_nxt, 2'b00};
		if (p_cur[15]) begin
			p_nxt = p_cur + c4 + DecNeg;
		end else begin
			p_nxt = p_cur + c4 - r4 + DecPos;
		end
		c_nxt = c_cur + 11'd1;
		done  = $signed(c_nxt) > $signed(r_nxt);
	end

	assign in_ready  = !full;
	assign push      = in_valid && in_ready && live;
	assign job.col   = c_cur;
	assign job.row   = r_cur;
	assign job.start = restart;
	assign job.done  = done;
	assign job.lower = lower;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			dec_q     <= '0;
			walking_q <= 1'b0;
		end else if (push) begin
			col_q     <= c_nxt;
			row_q     <= r_nxt;
			dec_q     <= p_nxt;
			walking_q <= !done;
		end
	end

	// the column that closes the arc leaves the walk idle
	`MCR_ASSERT_NEXT(a_done_stops_walk, clk, arst_n, push && job.done, !walking_q, "walk still active after final column")

endmodule

FILE: rtl/mcr_queue.sv
// short column queue between front end and pixel back end
// depends on mcr_pkg and the assertion macros header
`include "midpoint_circle_rasterizer_defines.svh"

module mcr_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mcr_pkg::job_t job_in,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output mcr_pkg::job_t head
);
	import mcr_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// never written when full unless the head leaves in the same cycle
	`MCR_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !full || pop, "column queue overflow")

endmodule

FILE: rtl/mcr_back.sv
// back end: emits the mirrored pixels of each queued column, one per cycle while out_ready allows
// depends on mcr_pkg and the assertion macros header
`include "midpoint_circle_rasterizer_defines.svh"

module mcr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  mcr_pkg::job_t     head,
	output logic              pop,
	input  logic [9:0]        center_x,
	input  logic [9:0]        center_y,
	input  logic [3:0]        pen_color,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [11:0] pixel_x,
	output logic signed [11:0] pixel_y,
	output logic [3:0]        pixel_color,
	output logic              last_of_step,
	output logic              arc_done
);
	import mcr_pkg::*;

	// pixel kinds, in emission order for full mode
	localparam logic [3:0] KindPcPr   = 4'd0;
	localparam logic [3:0] KindNcPr   = 4'd1;
	localparam logic [3:0] KindPcNr   = 4'd2;
	localparam logic [3:0] KindNcNr   = 4'd3;
	localparam logic [3:0] KindNrPc   = 4'd4;
	localparam logic [3:0] KindPrPc   = 4'd5;
	localparam logic [3:0] KindPrNc   = 4'd6;
	localparam logic [3:0] KindNrNc   = 4'd7;
	localparam logic [3:0] KindCenter = 4'd8;

	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic [11:0] x_q, y_q;
	logic [3:0]  color_q;
	logic        last_q, done_q;

	logic [2:0]  last_idx;
	logic [3:0]  kind;
	logic [11:0] c12, r12, dx, dy;
	logic        advance, is_last;

	always_comb begin
		if (head.lower) begin
			last_idx = head.start ? 3'd2 : 3'd1;
		end else begin
			last_idx = 3'd7;
		end
		if (head.lower && head.start) begin
			kind = (idx_q == 3'd0) ? KindCenter : {1'b0, idx_q - 3'd1};
		end else begin
			kind = {1'b0, idx_q};
		end
		c12 = {head.col[10], head.col};
		r12 = {head.row[10], head.row};
		case (kind)
			KindPcPr: begin dx = c12;       dy = r12;       end
			KindNcPr: begin dx = 12'd0 - c12; dy = r12;     end
			KindPcNr: begin dx = c12;       dy = 12'd0 - r12; end
			KindNcNr: begin dx = 12'd0 - c12; dy = 12'd0 - r12; end
			KindNrPc: begin dx = 12'd0 - r12; dy = c12;     end
			KindPrPc: begin dx = r12;       dy = c12;       end
			KindPrNc: begin dx = r12;       dy = 12'd0 - c12; end
			KindNrNc: begin dx = 12'd0 - r12; dy = 12'd0 - c12; end
			default:  begin dx = 12'd0;     dy = 12'd0;     end
		endcase
		advance = head_valid && (!out_valid_q || out_ready);
		is_last = (idx_q == last_idx);
	end

	assign pop = advance && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_q     <= {2'b00, center_x} + dx;
			y_q     <= {2'b00, center_y} + dy;
			color_q <= pen_color;
			last_q  <= is_last;
			done_q  <= head.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = x_q;
	assign pixel_y      = y_q;
	assign pixel_color  = color_q;
	assign last_of_step = last_q;
	assign arc_done     = done_q;

	// pixel index stays inside the column's pixel count
	`MCR_ASSERT_NOW(a_idx_range, clk, arst_n, head_valid, idx_q <= last_idx, "pixel index past end of column")
	// a finished column restarts the pixel index
	`MCR_ASSERT_NEXT(a_idx_wrap, clk, arst_n, pop, idx_q == 3'd0, "pixel index not cleared after column")

endmodule

FILE: rtl/midpoint_circle_rasterizer.sv
// a column's first pixel is registered in the queue, then in the back end's output stage
// output: one pixel per cycle while out_ready holds; a column has 8 pixels in full mode,
// 2 in lower-arc mode and 3 on a lower-arc restart; a tick while idle queues no column
// the front end takes a new beat every cycle while the column queue has room
// reset: walk idle, queue and output empty, centre and radius 0, colour 14, full mode
// depends on mcr_pkg, mcr_front, mcr_queue, mcr_back
module midpoint_circle_rasterizer #(
	parameter int COORD_BITS  = 10,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [9:0]        cfg_data,
	// tick channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              restart,
	// pixel channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [11:0] pixel_x,
	output logic signed [11:0] pixel_y,
	output logic [3:0]        pixel_color,
	output logic              last_of_step,
	output logic              arc_done
);
	import mcr_pkg::*;

	// coordinates are held to COORD_BITS, never wider than the 10-bit registers
	localparam int          EffBits   = (COORD_BITS < 10) ? COORD_BITS : 10;
	localparam logic [10:0] MaskWide  = (11'd1 << EffBits) - 11'd1;
	localparam logic [9:0]  CoordMask = MaskWide[9:0];

	logic [9:0] center_x_q, center_y_q, radius_q;
	logic [3:0] pen_color_q;
	logic       arc_mode_q;

	logic  full, push, pop, head_valid;
	job_t  job, head;

	// configuration registers, masked on write so every later read sees the clipped value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= '0;
			center_y_q  <= '0;
			radius_q    <= '0;
			pen_color_q <= ColorYellow;
			arc_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegCenterX:  center_x_q  <= cfg_data & CoordMask;
				RegCenterY:  center_y_q  <= cfg_data & CoordMask;
				RegRadius:   radius_q    <= cfg_data & CoordMask;
				RegPenColor: pen_color_q <= cfg_data[3:0];
				RegArcMode:  arc_mode_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// front end: one beat per cycle unless full; advances the walk and queues a column
	mcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.radius   (radius_q),
		.lower    (arc_mode_q),
		.full     (full),
		.push     (push),
		.job      (job)
	);

	// decouples the walk from the pixel stream
	mcr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.job_in     (job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back end: mirrors each column into its pixels through a registered output stage
	mcr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.center_x     (center_x_q),
		.center_y     (center_y_q),
		.pen_color    (pen_color_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.last_of_step (last_of_step),
		.arc_done     (arc_done)
	);

endmodule
